>>> src/lower_triangular_matrix_multiply_defines.svh
// Assertion macros used by the checker of the triangular matrix multiplier
`ifndef LOWER_TRIANGULAR_MATRIX_MULTIPLY_DEFINES_SVH
`define LOWER_TRIANGULAR_MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LTMM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ltmm assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LTMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ltmm assertion failed");

`endif

>>> src/ltmm_pkg.sv
// Shared constants, types and helpers of the triangular matrix multiplier
package ltmm_pkg;

	localparam int MAX_DIM     = 8;
	localparam int STORE_DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
	localparam int ELEM_W      = 16;
	localparam int PROD_W      = 32;
	localparam int CFG_W       = 4;
	localparam int ROW_W       = 3;
	localparam int DIM_W       = $clog2(MAX_DIM + 1);
	localparam int IDX_W       = ($clog2(MAX_DIM) > ROW_W) ? $clog2(MAX_DIM) : ROW_W;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1) + 1;
	localparam int CQ_DEPTH    = 2;
	localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
	localparam int OQ_DEPTH    = 4;
	localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

	localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

	// one classified input item on its way to the back end
	typedef struct packed {
		logic signed [ELEM_W-1:0] a;
		logic signed [ELEM_W-1:0] b;
		logic [ADDR_W-1:0]        addr;
		logic                     run_end;
		logic [DIM_W-1:0]         n;
	} ld_cmd_t;

	// one product element waiting for the receiver
	typedef struct packed {
		logic [PROD_W-1:0] value;
		logic [ROW_W-1:0]  row;
		logic [ROW_W-1:0]  col;
		logic              last;
	} res_t;

	// start offset of a row in the packed triangle
	function automatic logic [CNT_W-1:0] tri_num(input int unsigned v);
		int unsigned t;
		t = (v * (v + 1)) >> 1;
		return t[CNT_W-1:0];
	endfunction

endpackage

>>> src/ltmm_queue.sv
// Two-entry command queue between the front and the back end
module ltmm_queue import ltmm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  ld_cmd_t push_cmd,
	output logic    pop_valid,
	input  logic    pop_ready,
	output ld_cmd_t pop_cmd
);

	ld_cmd_t              mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0]  wr_ptr_q;
	logic [CQ_PTR_W-1:0]  rd_ptr_q;
	logic [CQ_PTR_W:0]    count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != (CQ_PTR_W+1)'(CQ_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> src/ltmm_front.sv
// Front end: holds the dimension, counts loads and tags each item with its store slot
module ltmm_front import ltmm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [ELEM_W-1:0] a_element,
	input  logic signed [ELEM_W-1:0] b_element,
	output logic                     push_valid,
	input  logic                     push_ready,
	output ld_cmd_t                  push_cmd
);

	logic [CFG_W-1:0] dim_q;
	logic [CNT_W-1:0] load_count_q;
	logic [DIM_W-1:0] n_eff;
	logic [CNT_W-1:0] total;
	logic [CNT_W-1:0] base;
	logic [CNT_W-1:0] next_count;
	logic             run_end;

	always_comb begin
		if (dim_q == '0) begin
			n_eff = DIM_W'(1);
		end else if (dim_q > CFG_W'(MAX_DIM)) begin
			n_eff = DIM_W'(MAX_DIM);
		end else begin
			n_eff = dim_q[DIM_W-1:0];
		end
	end

	assign total      = tri_num(int'(n_eff));
	assign base       = (load_count_q >= total) ? '0 : load_count_q;
	assign next_count = base + 1'b1;
	assign run_end    = (next_count == total);

	assign in_ready         = push_ready;
	assign push_valid       = in_valid;
	assign push_cmd.a       = a_element;
	assign push_cmd.b       = b_element;
	assign push_cmd.addr    = base[ADDR_W-1:0];
	assign push_cmd.run_end = run_end;
	assign push_cmd.n       = n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q        <= DIM_RESET;
			load_count_q <= '0;
		end else if (cfg_write) begin
			dim_q        <= cfg_data;
			load_count_q <= '0;
		end else if (in_valid && push_ready) begin
			load_count_q <= run_end ? '0 : next_count;
		end
	end

endmodule

>>> src/ltmm_back.sv
// Back end: element stores, multiply-accumulate pipeline and result queue
module ltmm_back import ltmm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  ld_cmd_t           pop_cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              out_res
);

	typedef enum logic {ST_LOAD, ST_CALC} state_t;

	state_t                   state_q;
	logic [IDX_W-1:0]         i_q;
	logic [IDX_W-1:0]         j_q;
	logic [IDX_W-1:0]         k_q;
	logic [DIM_W-1:0]         n_q;
	logic [IDX_W-1:0]         last_row;
	logic                     issue;
	logic                     elem_start;
	logic [CNT_W-1:0]         rd_a;
	logic [CNT_W-1:0]         rd_b;

	logic signed [ELEM_W-1:0] left_mem  [STORE_DEPTH];
	logic signed [ELEM_W-1:0] right_mem [STORE_DEPTH];

	logic                     vld_s1, first_s1, lastk_s1, end_s1;
	logic [IDX_W-1:0]         row_s1, col_s1;
	logic signed [ELEM_W-1:0] a_s1, b_s1;
	logic                     vld_s2, first_s2, lastk_s2, end_s2;
	logic [IDX_W-1:0]         row_s2, col_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic [PROD_W-1:0]        acc_q;
	logic [PROD_W-1:0]        sum;
	logic                     res_push;

	res_t                     oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]      oq_wr_q;
	logic [OQ_PTR_W-1:0]      oq_rd_q;
	logic [OQ_CNT_W-1:0]      oq_cnt_q;
	logic [OQ_CNT_W-1:0]      inflight_q;
	logic [OQ_CNT_W:0]        reserved;
	logic                     res_pop;
	logic                     do_load;

	assign pop_ready  = (state_q == ST_LOAD);
	assign do_load    = pop_valid && pop_ready;
	assign last_row   = IDX_W'(n_q - DIM_W'(1));
	assign elem_start = (k_q == j_q);
	assign reserved   = {1'b0, inflight_q} + {1'b0, oq_cnt_q};
	assign issue      = (state_q == ST_CALC) &&
	                    (!elem_start || (reserved < (OQ_CNT_W+1)'(OQ_DEPTH)));
	assign rd_a       = tri_num(int'(i_q)) + CNT_W'(k_q);
	assign rd_b       = tri_num(int'(k_q)) + CNT_W'(j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			n_q     <= DIM_W'(1);
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (do_load && pop_cmd.run_end) begin
						n_q     <= pop_cmd.n;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (issue) begin
						if (k_q == i_q) begin
							if (j_q == i_q) begin
								if (i_q == last_row) begin
									state_q <= ST_LOAD;
								end
								i_q <= i_q + 1'b1;
								j_q <= '0;
								k_q <= '0;
							end else begin
								j_q <= j_q + 1'b1;
								k_q <= j_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// element stores
	always_ff @(posedge clk) begin
		if (do_load) begin
			left_mem[pop_cmd.addr]  <= pop_cmd.a;
			right_mem[pop_cmd.addr] <= pop_cmd.b;
		end
		a_s1 <= left_mem[rd_a[ADDR_W-1:0]];
		b_s1 <= right_mem[rd_b[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= elem_start;
		lastk_s1 <= (k_q == i_q);
		end_s1   <= (k_q == i_q) && (j_q == i_q) && (i_q == last_row);
		row_s1   <= i_q;
		col_s1   <= j_q;
		first_s2 <= first_s1;
		lastk_s2 <= lastk_s1;
		end_s2   <= end_s1;
		row_s2   <= row_s1;
		col_s2   <= col_s1;
		prod_s2  <= a_s1 * b_s1;
	end

	assign sum      = first_s2 ? prod_s2 : acc_q + prod_s2;
	assign res_push = vld_s2 && lastk_s2;

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_q <= sum;
		end
		if (res_push) begin
			oq_q[oq_wr_q] <= '{value: sum, row: row_s2[ROW_W-1:0],
			                   col: col_s2[ROW_W-1:0], last: end_s2};
		end
	end

	// result queue, slots reserved when an element starts
	assign out_valid = (oq_cnt_q != '0);
	assign out_res   = oq_q[oq_rd_q];
	assign res_pop   = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q    <= '0;
			oq_rd_q    <= '0;
			oq_cnt_q   <= '0;
			inflight_q <= '0;
		end else begin
			if (res_push) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (res_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			if (res_push && !res_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (!res_push && res_pop) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
			if ((issue && elem_start) && !res_push) begin
				inflight_q <= inflight_q + 1'b1;
			end else if (!(issue && elem_start) && res_push) begin
				inflight_q <= inflight_q - 1'b1;
			end
		end
	end

endmodule

>>> src/lower_triangular_matrix_multiply.sv
// Top level of the packed lower triangular matrix multiplier
// Usage:
//   Input channel (in_valid/in_ready) carries one element of A and one of B per item,
//   packed row-major over the lower triangle. cfg_write/cfg_data set the dimension
//   (0 acts as 1, above 8 acts as 8) and restart the load count; write only when idle.
//   Output channel (out_valid/out_ready) gives C = A*B packed row-major, with row and
//   column on each element and last on the final element. Sums wrap at 32 bits.
// Timing:
//   Loads are taken at one item per cycle while the two-entry command queue has room.
//   After the final item of a run, element C[i][j] sums i-j+1 products of the single
//   16x16 multiplier; with the back end idle the first result passes the s1 and s2
//   registers and then the result queue before it is valid.
//   For dimension 8 a run is 36 loads and 120 products.
//   While the product of a run is computed, at most two further items are taken.
// Reset and stall:
//   Reset sets the dimension to 8 and empties both queues. A stalled receiver holds
//   the head result; up to four results are buffered before the multiplier pauses.
module lower_triangular_matrix_multiply import ltmm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [ELEM_W-1:0] a_element,
	input  logic signed [ELEM_W-1:0] b_element,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [PROD_W-1:0] product_element,
	output logic [ROW_W-1:0]         row,
	output logic [ROW_W-1:0]         column,
	output logic                     last
);

	logic    push_valid;
	logic    push_ready;
	ld_cmd_t push_cmd;
	logic    pop_valid;
	logic    pop_ready;
	ld_cmd_t pop_cmd;
	res_t    out_res;

	ltmm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.a_element  (a_element),
		.b_element  (b_element),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	ltmm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	ltmm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign product_element = out_res.value;
	assign row             = out_res.row;
	assign column          = out_res.col;
	assign last            = out_res.last;

endmodule

>>> src/ltmm_checker.sv
// Port-level checker of the triangular matrix multiplier and its bind
`include "lower_triangular_matrix_multiply_defines.svh"

module ltmm_checker import ltmm_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic signed [ELEM_W-1:0] a_element,
	input logic signed [ELEM_W-1:0] b_element,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [PROD_W-1:0] product_element,
	input logic [ROW_W-1:0]         row,
	input logic [ROW_W-1:0]         column,
	input logic                     last
);

	`LTMM_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(a_element) && $stable(b_element))
	`LTMM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(product_element) && $stable(row) && $stable(column) && $stable(last))
	`LTMM_ASSERT_NOW(a_col_le_row, clk, arst_n, out_valid, column <= row)
	`LTMM_ASSERT_NOW(a_last_diag, clk, arst_n, out_valid && last, column == row)
	`LTMM_ASSERT_NEXT(a_run_restart, clk, arst_n, out_valid && out_ready && last, !out_valid || (row == '0 && column == '0))

endmodule

bind lower_triangular_matrix_multiply ltmm_checker u_ltmm_checker (.*);

>>> tb/lower_triangular_matrix_multiply_tb.sv
// Self-checking testbench for the packed lower triangular matrix multiplier
`timescale 1ns / 100ps

module lower_triangular_matrix_multiply_tb;
	import ltmm_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 450;
	localparam int DRAIN_CYCLES  = 16;
	localparam int TAIL_CYCLES   = 50;
	localparam int LONG_HOLD     = 400;
	localparam int TIMEOUT_NS    = 10_000_000;
	localparam int DIRECTED_ROWS = 23;

	typedef struct packed {
		logic              write_dim;
		logic [CFG_W-1:0]  dim;
		logic [ELEM_W-1:0] a;
		logic [ELEM_W-1:0] b;
		logic              typed;
		logic [PROD_W-1:0] product;
	} directed_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_write;
	logic [CFG_W-1:0]         cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [ELEM_W-1:0] a_element;
	logic signed [ELEM_W-1:0] b_element;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [PROD_W-1:0] product_element;
	logic [ROW_W-1:0]         row;
	logic [ROW_W-1:0]         column;
	logic                     last;

	directed_row_t directed_rows [DIRECTED_ROWS];

	logic signed [ELEM_W-1:0] left_mem [STORE_DEPTH];
	logic signed [ELEM_W-1:0] right_mem [STORE_DEPTH];
	logic [CFG_W-1:0]         dim_reg;
	int unsigned              fill_count;
	res_t                     expected_products [$];

	bit          valid_held;
	bit          no_idle;
	bit          hold_request;
	int unsigned stall_left;
	int unsigned errors;
	int unsigned items_sent;
	int unsigned elements_checked;
	int unsigned products_done;
	int unsigned dim_writes;
	int unsigned restarts;
	logic [MAX_DIM:1] dims_covered;

	lower_triangular_matrix_multiply dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.a_element       (a_element),
		.b_element       (b_element),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.product_element (product_element),
		.row             (row),
		.column          (column),
		.last            (last)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic int unsigned tri_base(input int unsigned v);
		return v * (v + 1) / 2;
	endfunction

	function automatic int unsigned effective_dim(input logic [CFG_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return d;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ELEM_W-1:0] pick_element();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_dimension();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 4'd0;
		if (r == 1)
			return CFG_W'($urandom_range(MAX_DIM + 1, 15));
		if (r < 5)
			return CFG_W'(MAX_DIM);
		return CFG_W'($urandom_range(1, MAX_DIM - 1));
	endfunction

	task automatic load_element_pair(input logic signed [ELEM_W-1:0] a,
			input logic signed [ELEM_W-1:0] b);
		int unsigned n;
		int unsigned total;
		logic [PROD_W-1:0] sum;
		logic signed [PROD_W-1:0] term;
		res_t r;
		n = effective_dim(dim_reg);
		total = tri_base(n);
		if (fill_count >= total)
			fill_count = 0;
		left_mem[fill_count] = a;
		right_mem[fill_count] = b;
		fill_count++;
		if (fill_count < total)
			return;
		fill_count = 0;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j <= i; j++) begin
				sum = '0;
				for (int k = j; k <= i; k++) begin
					term = left_mem[tri_base(i) + k] * right_mem[tri_base(k) + j];
					sum += term;
				end
				r.value = sum;
				r.row = i[ROW_W-1:0];
				r.col = j[ROW_W-1:0];
				r.last = (i == n - 1) && (j == i);
				expected_products.push_back(r);
			end
		end
		products_done++;
		dims_covered[n] = 1'b1;
	endtask

	task automatic send_item(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b);
		int unsigned gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			if (valid_held)
				in_valid <= 1'b0;
			valid_held = 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		a_element <= a;
		b_element <= b;
		valid_held = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		items_sent++;
		load_element_pair(a, b);
	endtask

	task automatic wait_until_idle();
		if (valid_held)
			in_valid <= 1'b0;
		valid_held = 1'b0;
		while (expected_products.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_dimension(input logic [CFG_W-1:0] value);
		wait_until_idle();
		cfg_data <= value;
		cfg_write <= 1'b1;
		@(posedge clk);
		cfg_write <= 1'b0;
		dim_reg = value;
		fill_count = 0;
		dim_writes++;
	endtask

	task automatic check_product();
		res_t want;
		elements_checked++;
		if (expected_products.size() == 0) begin
			$display("%0t: unexpected product element expected none actual %h row %0d column %0d",
				$time, product_element, row, column);
			errors++;
			return;
		end
		want = expected_products.pop_front();
		if (product_element !== want.value) begin
			$display("%0t: product_element expected %h actual %h", $time, want.value,
				product_element);
			errors++;
		end
		if (row !== want.row) begin
			$display("%0t: row expected %0d actual %0d", $time, want.row, row);
			errors++;
		end
		if (column !== want.col) begin
			$display("%0t: column expected %0d actual %0d", $time, want.col, column);
			errors++;
		end
		if (last !== want.last) begin
			$display("%0t: last expected %b actual %b", $time, want.last, last);
			errors++;
		end
	endtask

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1)
				check_product();
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!no_idle)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("lower_triangular_matrix_multiply_tb failed");
		$finish;
	end

	initial begin
		int unsigned queued;
		int unsigned run_idx;
		int unsigned random_items;
		int unsigned total;
		int unsigned length;
		bit change;
		bit broken;

		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		a_element <= '0;
		b_element <= '0;
		dim_reg = DIM_RESET;
		fill_count = 0;
		dims_covered = '0;
		foreach (left_mem[i]) begin
			left_mem[i] = '0;
			right_mem[i] = '0;
		end

		directed_rows = '{
			'{1'b0, 4'd0,  16'h7FFF, 16'h8000, 1'b0, 32'h0},
			'{1'b0, 4'd0,  16'h1234, 16'hFEDC, 1'b0, 32'h0},
			'{1'b0, 4'd0,  16'hFFFF, 16'h0001, 1'b0, 32'h0},
			'{1'b1, 4'd1,  16'h7FFF, 16'h7FFF, 1'b1, 32'h3FFF0001},
			'{1'b0, 4'd0,  16'h8000, 16'h8000, 1'b1, 32'h40000000},
			'{1'b0, 4'd0,  16'h8000, 16'h7FFF, 1'b1, 32'hC0008000},
			'{1'b0, 4'd0,  16'h0000, 16'hFFFF, 1'b1, 32'h00000000},
			'{1'b0, 4'd0,  16'hFFFF, 16'hFFFF, 1'b1, 32'h00000001},
			'{1'b1, 4'd0,  16'h0001, 16'h8000, 1'b1, 32'hFFFF8000},
			'{1'b1, 4'd15, 16'h0005, 16'h0006, 1'b0, 32'h0},
			'{1'b0, 4'd0,  16'h0007, 16'h0008, 1'b0, 32'h0},
			'{1'b1, 4'd2,  16'h8000, 16'h8000, 1'b0, 32'h0},
			'{1'b0, 4'd0,  16'h8000, 16'h8000, 1'b0, 32'h0},
			'{1'b0, 4'd0,  16'h8000, 16'h8000, 1'b0, 32'h0},
			'{1'b1, 4'd3,  16'h8000, 16'h8000, 1'b0, 32'h0},
			'{1'b0, 4'd0,  16'h8000, 16'h8000, 1'b0, 32'h0},
			'{1'b0, 4'd0,  16'h8000, 16'h8000, 1'b0, 32'h0},
			'{1'b0, 4'd0,  16'h8000, 16'h8000, 1'b0, 32'h0},
			'{1'b0, 4'd0,  16'h8000, 16'h8000, 1'b0, 32'h0},
			'{1'b0, 4'd0,  16'h8000, 16'h8000, 1'b0, 32'h0},
			'{1'b1, 4'd2,  16'h7FFF, 16'h8000, 1'b0, 32'h0},
			'{1'b0, 4'd0,  16'h8000, 16'h7FFF, 1'b0, 32'h0},
			'{1'b0, 4'd0,  16'h7FFF, 16'h7FFF, 1'b0, 32'h0}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_rows[r].write_dim)
				write_dimension(directed_rows[r].dim);
			queued = expected_products.size();
			send_item(directed_rows[r].a, directed_rows[r].b);
			if (directed_rows[r].typed && expected_products.size() == queued + 1)
				expected_products[queued].value = directed_rows[r].product;
		end

		run_idx = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			change = (run_idx != 2) && (run_idx < 4 || $urandom_range(0, 2) == 0);
			if (change) begin
				case (run_idx)
					0: write_dimension(CFG_W'(MAX_DIM));
					1: write_dimension(4'd15);
					3: write_dimension(4'd1);
					default: write_dimension(pick_dimension());
				endcase
			end
			total = tri_base(effective_dim(dim_reg));
			no_idle = (run_idx == 1 || run_idx == 2) || ($urandom_range(0, 4) == 0);
			if (run_idx == 1)
				hold_request = 1'b1;
			broken = (run_idx >= 4) && (total > 1) && ($urandom_range(0, 7) == 0);
			length = broken ? $urandom_range(1, total - 1) : total;
			repeat (length) begin
				send_item(pick_element(), pick_element());
				random_items++;
			end
			if (broken) begin
				write_dimension(pick_dimension());
				restarts++;
			end else if ($urandom_range(0, 5) == 0) begin
				wait_until_idle();
			end
			run_idx++;
		end
		no_idle = 1'b0;

		wait_until_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d items, checked %0d product elements from %0d complete products",
			items_sent, elements_checked, products_done);
		$display("Dimensions covered (bit per size) %b, %0d dimension writes, %0d restarts",
			dims_covered, dim_writes, restarts);
		if (errors == 0)
			$display("lower_triangular_matrix_multiply_tb passed");
		else
			$display("lower_triangular_matrix_multiply_tb failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/ltmm_pkg.sv
src/ltmm_queue.sv
src/ltmm_front.sv
src/ltmm_back.sv
src/lower_triangular_matrix_multiply.sv
src/ltmm_checker.sv
tb/lower_triangular_matrix_multiply_tb.sv
